// ===== rtl/bqgf_pkg.sv =====
// package for the biquad filter: widths, register indexes and the sequencer microcode
`timescale 1ns / 1ps

package bqgf_pkg;

  // default filter sizes
  localparam int BQGF_SAMPLE_BITS    = 24;
  localparam int BQGF_COEF_FRAC_BITS = 20;

  // coefficient registers are always signed 24-bit
  localparam int COEF_BITS = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int PC_BITS = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5,
    REG_FORM = 3'd6
  } cfg_idx_e;

  // multiplier operand pair for one step
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_B0X,
    MUL_B1X1,
    MUL_B2X2,
    MUL_A1Y1,
    MUL_A2Y2,
    MUL_GFF
  } mul_sel_e;

  // accumulator operation for one step (works on the product of the previous step)
  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LD,
    ACC_ADD,
    ACC_SUB,
    ACC_LDX,
    ACC_FF,
    ACC_OUT
  } acc_op_e;

  // sequencing of the step counter
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GAIN,
    JMP_GO
  } jmp_e;

  typedef struct packed {
    mul_sel_e            mul;
    acc_op_e             acc;
    jmp_e                jmp;
    logic [PC_BITS-1:0]  target;
  } ucode_t;

  localparam logic [PC_BITS-1:0] PC_START = 4'd0;
  localparam logic [PC_BITS-1:0] PC_GAIN  = 4'd8;

  // microcode program
  // standard form: steps 0..6, gain form: step 0 then 8..15
  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = '{mul: MUL_NONE, acc: ACC_NOP, jmp: JMP_GO, target: PC_START};
    case (pc)
      4'd0:  w = '{mul: MUL_B1X1, acc: ACC_NOP, jmp: JMP_GAIN, target: PC_GAIN};
      4'd1:  w = '{mul: MUL_B0X,  acc: ACC_LD,  jmp: JMP_NEXT, target: PC_START};
      4'd2:  w = '{mul: MUL_B2X2, acc: ACC_ADD, jmp: JMP_NEXT, target: PC_START};
      4'd3:  w = '{mul: MUL_A1Y1, acc: ACC_ADD, jmp: JMP_NEXT, target: PC_START};
      4'd4:  w = '{mul: MUL_A2Y2, acc: ACC_SUB, jmp: JMP_NEXT, target: PC_START};
      4'd5:  w = '{mul: MUL_NONE, acc: ACC_SUB, jmp: JMP_NEXT, target: PC_START};
      4'd6:  w = '{mul: MUL_NONE, acc: ACC_OUT, jmp: JMP_GO,   target: PC_START};
      4'd8:  w = '{mul: MUL_B2X2, acc: ACC_LDX, jmp: JMP_NEXT, target: PC_START};
      4'd9:  w = '{mul: MUL_NONE, acc: ACC_ADD, jmp: JMP_NEXT, target: PC_START};
      4'd10: w = '{mul: MUL_NONE, acc: ACC_FF,  jmp: JMP_NEXT, target: PC_START};
      4'd11: w = '{mul: MUL_GFF,  acc: ACC_NOP, jmp: JMP_NEXT, target: PC_START};
      4'd12: w = '{mul: MUL_A1Y1, acc: ACC_LD,  jmp: JMP_NEXT, target: PC_START};
      4'd13: w = '{mul: MUL_A2Y2, acc: ACC_SUB, jmp: JMP_NEXT, target: PC_START};
      4'd14: w = '{mul: MUL_NONE, acc: ACC_SUB, jmp: JMP_NEXT, target: PC_START};
      4'd15: w = '{mul: MUL_NONE, acc: ACC_OUT, jmp: JMP_GO,   target: PC_START};
      default: w = '{mul: MUL_NONE, acc: ACC_NOP, jmp: JMP_GO, target: PC_START};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/biquad_filter_with_gain_form_top.sv =====
// biquad direct form I filter with optional gain-scaled feedforward, microcoded datapath
//
// Usage:
//   sample_in is a valid/ready channel of signed samples; sample_out is a valid/ready
//   channel of filtered, saturated samples, one per input sample.
//   Coefficients and the form select are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while no sample is in flight; writes to unknown indexes are dropped.
//   One shared multiplier is stepped through a microcode program, at most one product
//   per cycle, with the accumulate working on the registered product of the step before.
//   The time per sample is set by the number of microcode steps through the single
//   multiplier, which is larger in the gain form. The result is written to the output
//   register at the final step of the program.
//   A new sample is taken in the cycle the previous result is written to the output
//   register, so back-to-back samples follow each other without a gap.
//   If the receiver stalls, the finished result waits in the output register; the
//   next sample still runs until its own result step, where it holds.
//   Reset clears the history to zero, sets b0 and gain to 1.0, the other
//   coefficients to zero and selects the standard form.
`timescale 1ns / 1ps

module biquad_filter_with_gain_form_top
  import bqgf_pkg::*;
#(
  parameter int SAMPLE_BITS    = BQGF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = BQGF_COEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [COEF_BITS-1:0]          cfg_data_i,
  // input samples
  input  logic                          sample_in_valid_i,
  output logic                          sample_in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // output samples
  output logic                          sample_out_valid_o,
  input  logic                          sample_out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int OPW  = SAMPLE_BITS + 6;
  localparam int PW   = COEF_BITS + OPW;
  localparam int ACCW = PW + 2;

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [ACCW-1:0] RND_HALF =
    {{(ACCW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] Y_MAX = {{(ACCW-SAMPLE_BITS+1){1'b0}},
                                              {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACCW-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [ACCW-1:0] FF_MAX = {{(ACCW-OPW+1){1'b0}}, {(OPW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] FF_MIN = ~FF_MAX;

  // configuration registers
  logic signed [COEF_BITS-1:0] b0_q, b1_q, b2_q, a1_q, a2_q, gain_q;
  logic                        form_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= COEF_ONE;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      gain_q <= COEF_ONE;
      form_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_B0:   b0_q   <= cfg_data_i;
        REG_B1:   b1_q   <= cfg_data_i;
        REG_B2:   b2_q   <= cfg_data_i;
        REG_A1:   a1_q   <= cfg_data_i;
        REG_A2:   a2_q   <= cfg_data_i;
        REG_GAIN: gain_q <= cfg_data_i;
        REG_FORM: form_q <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // sequencer control
  logic               busy_q, busy_d;
  logic [PC_BITS-1:0] pc_q, pc_d;
  ucode_t             uw;
  logic               out_step, out_stall, out_fire, in_xfer;

  assign uw        = ucode_rom(pc_q);
  assign out_step  = busy_q && (uw.acc == ACC_OUT);
  assign out_stall = sample_out_valid_o && !sample_out_ready_i;
  assign out_fire  = out_step && !out_stall;

  assign sample_in_ready_o = !busy_q || out_fire;
  assign in_xfer           = sample_in_valid_i && sample_in_ready_o;

  // next step and busy flag
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (in_xfer) begin
      busy_d = 1'b1;
      pc_d   = PC_START;
    end else if (out_fire) begin
      busy_d = 1'b0;
      pc_d   = PC_START;
    end else if (busy_q && !out_step) begin
      unique case (uw.jmp)
        JMP_NEXT: pc_d = pc_q + 1'b1;
        JMP_GAIN: pc_d = form_q ? uw.target : pc_q + 1'b1;
        JMP_GO:   pc_d = uw.target;
        default:  pc_d = PC_START;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_START;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  // sample capture and history
  logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= sample_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (out_fire) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= y_sat;
    end
  end

  // shared multiplier with registered product
  logic signed [COEF_BITS-1:0] mc;
  logic signed [OPW-1:0]       mo, ff_q;
  logic signed [PW-1:0]        prod_q;

  always_comb begin
    mc = gain_q;
    mo = ff_q;
    unique case (uw.mul)
      MUL_B0X: begin
        mc = b0_q;
        mo = {{6{x_q[SAMPLE_BITS-1]}}, x_q};
      end
      MUL_B1X1: begin
        mc = b1_q;
        mo = {{6{x1_q[SAMPLE_BITS-1]}}, x1_q};
      end
      MUL_B2X2: begin
        mc = b2_q;
        mo = {{6{x2_q[SAMPLE_BITS-1]}}, x2_q};
      end
      MUL_A1Y1: begin
        mc = a1_q;
        mo = {{6{y1_q[SAMPLE_BITS-1]}}, y1_q};
      end
      MUL_A2Y2: begin
        mc = a2_q;
        mo = {{6{y2_q[SAMPLE_BITS-1]}}, y2_q};
      end
      MUL_GFF: begin
        mc = gain_q;
        mo = ff_q;
      end
      default: begin
        mc = gain_q;
        mo = ff_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && (uw.mul != MUL_NONE)) begin
      prod_q <= mc * mo;
    end
  end

  // accumulator, rounding and saturation
  logic signed [ACCW-1:0] acc_q, acc_d, prod_ext, x_shift, rnd;
  logic signed [OPW-1:0]  ff_sat;

  assign prod_ext = {{(ACCW-PW){prod_q[PW-1]}}, prod_q};
  assign x_shift  = {{(ACCW-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q} <<< COEF_FRAC_BITS;
  assign rnd      = (acc_q + RND_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    if (rnd > FF_MAX) begin
      ff_sat = FF_MAX[OPW-1:0];
    end else if (rnd < FF_MIN) begin
      ff_sat = FF_MIN[OPW-1:0];
    end else begin
      ff_sat = rnd[OPW-1:0];
    end
    if (rnd > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (rnd < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    case (uw.acc)
      ACC_LD:  acc_d = prod_ext;
      ACC_ADD: acc_d = acc_q + prod_ext;
      ACC_SUB: acc_d = acc_q - prod_ext;
      ACC_LDX: acc_d = x_shift + prod_ext;
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      acc_q <= acc_d;
    end
    if (busy_q && (uw.acc == ACC_FF)) begin
      ff_q <= ff_sat;
    end
  end

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_fire) begin
      out_valid_q <= 1'b1;
    end else if (sample_out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_q <= y_sat;
    end
  end

  assign sample_out_valid_o = out_valid_q;
  assign sample_out_o       = out_q;

endmodule

// ===== bench/tb_biquad_filter_with_gain_form_top.sv =====
// self-checking testbench for the biquad filter with standard and gain-scaled forms
`timescale 1ns / 1ps

module tb_biquad_filter_with_gain_form_top;
  import bqgf_pkg::*;

  localparam int SB      = BQGF_SAMPLE_BITS;
  localparam int FRAC    = BQGF_COEF_FRAC_BITS;
  localparam int FF_BITS = SB + 6;

  // index past the register list, writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  localparam logic [SB-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SB-1:0] S_MIN = 24'h800000;
  localparam logic [COEF_BITS-1:0] C_ONE = 24'h100000;

  // directed stimulus table
  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_op_e;
  typedef struct packed {
    row_op_e                 op;
    logic [CFG_IDX_BITS-1:0] idx;     // only used on write rows
    logic [SB-1:0]           value;
    logic                    known;   // result typed in below
    logic [SB-1:0]           result;
  } stim_row_t;

  localparam int DIR_ROWS = 27;

  // defaults pass samples through, then output clipping with b0 at both extremes
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_SAMPLE, REG_B0,     24'h000000, 1'b1, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b1, S_MAX},
    '{ROW_SAMPLE, REG_B0,     S_MIN,      1'b1, S_MIN},
    '{ROW_SAMPLE, REG_B0,     24'h000001, 1'b1, 24'h000001},
    '{ROW_SAMPLE, REG_B0,     24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{ROW_WRITE,  REG_B0,     S_MAX,      1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b1, S_MAX},
    '{ROW_SAMPLE, REG_B0,     S_MIN,      1'b1, S_MIN},
    '{ROW_WRITE,  REG_B0,     S_MIN,      1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b1, S_MIN},
    '{ROW_SAMPLE, REG_B0,     S_MIN,      1'b1, S_MAX},
    '{ROW_WRITE,  REG_UNUSED, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     24'h000123, 1'b0, 24'h000000},
    '{ROW_WRITE,  REG_B1,     S_MAX,      1'b0, 24'h000000},
    '{ROW_WRITE,  REG_B2,     S_MIN,      1'b0, 24'h000000},
    '{ROW_WRITE,  REG_A1,     S_MAX,      1'b0, 24'h000000},
    '{ROW_WRITE,  REG_A2,     S_MIN,      1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MIN,      1'b0, 24'h000000},
    '{ROW_WRITE,  REG_GAIN,   S_MAX,      1'b0, 24'h000000},
    '{ROW_WRITE,  REG_FORM,   24'hFFFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MIN,      1'b0, 24'h000000},
    '{ROW_WRITE,  REG_FORM,   24'hFFFFFE, 1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     24'h000001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, REG_B0,     S_MAX,      1'b0, 24'h000000}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [COEF_BITS-1:0] cfg_data_i = '0;
  logic                 sample_in_valid_i = 1'b0;
  logic                 sample_in_ready_o;
  logic signed [SB-1:0] sample_in_i = '0;
  logic                 sample_out_valid_o;
  logic                 sample_out_ready_i = 1'b0;
  logic signed [SB-1:0] sample_out_o;

  // filter copy: coefficients, form and history
  logic signed [COEF_BITS-1:0] coef_q [0:5];
  logic                        form_q;
  logic signed [SB-1:0]        hist_x1, hist_x2, hist_y1, hist_y2;

  logic [SB-1:0] filtered_q [$];
  logic [SB-1:0] want;
  int            err_count = 0;
  logic          no_idle = 1'b0;

  biquad_filter_with_gain_form_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .sample_in_valid_i  (sample_in_valid_i),
    .sample_in_ready_o  (sample_in_ready_o),
    .sample_in_i        (sample_in_i),
    .sample_out_valid_o (sample_out_valid_o),
    .sample_out_ready_i (sample_out_ready_i),
    .sample_out_o       (sample_out_o)
  );

  always #6 clk_i = ~clk_i;

  // round half up at coefficient scale
  function automatic longint round_q(input longint v);
    return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clip(input longint v, input int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // next filtered sample for input x under the current coefficients
  function automatic logic signed [SB-1:0] filter_out(input logic signed [SB-1:0] x);
    longint fb, ff, acc;
    fb = -longint'(coef_q[REG_A1]) * longint'(hist_y1)
         - longint'(coef_q[REG_A2]) * longint'(hist_y2);
    if (form_q) begin
      ff = (longint'(x) <<< FRAC) + longint'(coef_q[REG_B1]) * longint'(hist_x1)
           + longint'(coef_q[REG_B2]) * longint'(hist_x2);
      ff = clip(round_q(ff), FF_BITS);
      acc = longint'(coef_q[REG_GAIN]) * ff + fb;
    end else begin
      acc = longint'(coef_q[REG_B0]) * longint'(x)
            + longint'(coef_q[REG_B1]) * longint'(hist_x1)
            + longint'(coef_q[REG_B2]) * longint'(hist_x2) + fb;
    end
    return SB'(clip(round_q(acc), SB));
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? S_MAX : S_MIN;
      1: return SB'($urandom_range(510) - 255);
      default: return SB'($urandom);
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_sample(input logic [SB-1:0] x, input logic known,
                             input logic [SB-1:0] typed);
    logic signed [SB-1:0] y;
    while (!no_idle && $urandom_range(99) < 29) begin
      sample_in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    sample_in_valid_i = 1'b1;
    sample_in_i = x;
    @(posedge clk_i);
    while (!sample_in_ready_o) @(posedge clk_i);
    y = filter_out(x);
    filtered_q.push_back(known ? typed : y);
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = y;
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected sample has come out
  task automatic drain();
    sample_in_valid_i = 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] d);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = d;
    @(posedge clk_i);
    case (idx)
      REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_GAIN: coef_q[idx] = d;
      REG_FORM: form_q = d[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk_i);
      sample_out_ready_i = no_idle || ($urandom_range(99) >= 29);
    end
  end

  // output transfer check against the oldest expected sample
  always @(posedge clk_i) begin
    if (rst_ni && sample_out_valid_o && sample_out_ready_i) begin
      if (filtered_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected output sample %0d", sample_out_o);
      end else begin
        want = filtered_q.pop_front();
        if (sample_out_o !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("sample_out mismatch: expected %0d got %0d",
                     $signed(want), sample_out_o);
        end
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int r, ph, n;
    logic [COEF_BITS-1:0] val;

    // reset state of the filter copy
    coef_q[REG_B0] = C_ONE;
    coef_q[REG_B1] = '0;
    coef_q[REG_B2] = '0;
    coef_q[REG_A1] = '0;
    coef_q[REG_A2] = '0;
    coef_q[REG_GAIN] = C_ONE;
    form_q = 1'b0;
    hist_x1 = '0;
    hist_x2 = '0;
    hist_y1 = '0;
    hist_y2 = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].op == ROW_WRITE) begin
        drain();
        write_reg(dir_tab[r].idx, dir_tab[r].value);
      end else begin
        send_sample(dir_tab[r].value, dir_tab[r].known, dir_tab[r].result);
      end
    end

    // random phases: full range, small, and extreme coefficients in both forms
    for (ph = 0; ph < 10; ph++) begin
      drain();
      no_idle = (ph == 6);
      for (r = 0; r < 6; r++) begin
        case (ph % 3)
          0: val = COEF_BITS'($urandom);
          1: val = COEF_BITS'($urandom_range(2097152) - 1048576);
          default: begin
            if (ph == 2) val = S_MAX;
            else if (ph == 5) val = S_MIN;
            else begin
              case ($urandom_range(3))
                0: val = S_MAX;
                1: val = S_MIN;
                2: val = '0;
                default: val = C_ONE;
              endcase
            end
          end
        endcase
        write_reg(r[CFG_IDX_BITS-1:0], val);
      end
      write_reg(REG_UNUSED, COEF_BITS'($urandom));
      // form bit with random upper bits
      val = COEF_BITS'($urandom);
      val[0] = ph[0];
      write_reg(REG_FORM, val);
      for (n = 0; n < 113; n++) begin
        // sender holds off until the output side is empty
        if (ph == 3 && n == 56) drain();
        send_sample(rand_sample(), 1'b0, '0);
      end
    end

    // end of stimulus
    sample_in_valid_i = 1'b0;
    no_idle = 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_count == 0 && filtered_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
